[hdl/msgser_pkg.sv]
// ----------------------------------------------------------------------------
// msgser_pkg: shared definitions for the MessagePack subset serializer
// Action and status codes, header lead bytes and the job record that the
// front end hands to the emit stage.
// ----------------------------------------------------------------------------
`default_nettype none

package msgser_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int Q_DEPTH_DEF   = 2;
  localparam int CAP_WIDTH     = 32;
  localparam int LEN_WIDTH     = 32;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 32'd4096;

  // Input actions
  localparam logic [2:0] ACT_RESET   = 3'd0;
  localparam logic [2:0] ACT_MAP     = 3'd1;
  localparam logic [2:0] ACT_UINT    = 3'd2;
  localparam logic [2:0] ACT_STR     = 3'd3;
  localparam logic [2:0] ACT_BIN     = 3'd4;
  localparam logic [2:0] ACT_PAYLOAD = 3'd5;

  // Result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_UNEXP    = 2'd3;

  // Header lead bytes
  localparam logic [7:0] HB_FIXMAP = 8'h80;
  localparam logic [7:0] HB_MAP16  = 8'hde;
  localparam logic [7:0] HB_UINT8  = 8'hcc;
  localparam logic [7:0] HB_UINT16 = 8'hcd;
  localparam logic [7:0] HB_UINT32 = 8'hce;
  localparam logic [7:0] HB_UINT64 = 8'hcf;
  localparam logic [7:0] HB_FIXSTR = 8'ha0;
  localparam logic [7:0] HB_STR16  = 8'hda;
  localparam logic [7:0] HB_STR32  = 8'hdb;
  localparam logic [7:0] HB_BIN8   = 8'hc4;
  localparam logic [7:0] HB_BIN16  = 8'hc5;

  localparam logic [LEN_WIDTH-1:0] LEN16_MAX = 32'h0000_FFFF;

  localparam int HDR_MAX = 9;

  typedef logic [HDR_MAX-1:0][7:0] hdr_bytes_t;  // element 0 goes out first
  typedef logic [3:0]              hdr_cnt_t;

  // One queued job: cnt results, bytes[0..cnt-1]
  typedef struct packed {
    hdr_bytes_t bytes;
    hdr_cnt_t   cnt;
    logic       bvalid;
    logic [1:0] status;
  } job_t;

endpackage : msgser_pkg

`default_nettype wire

[hdl/msgser_front.sv]
// ----------------------------------------------------------------------------
// msgser_front: item classification and space accounting
// Decodes one item per cycle into a job, checks header plus payload
// against capacity and keeps write position and pending payload count.
// ----------------------------------------------------------------------------
`default_nettype none

module msgser_front
  import msgser_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [2:0]           in_action,
  input  wire logic [63:0]          in_value,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CAP_WIDTH-1:0] cfg_wr_data,
  output job_t                      job
);

  localparam int SW = ((POS_WIDTH > LEN_WIDTH) ? POS_WIDTH : LEN_WIDTH) + 2;

  logic [CAP_WIDTH-1:0] cap_r;
  logic [POS_WIDTH-1:0] wp_r, wp_nxt;
  logic [LEN_WIDTH-1:0] pl_r, pl_nxt;

  logic [LEN_WIDTH-1:0] len;
  logic [LEN_WIDTH-1:0] plen;
  hdr_bytes_t           hdr;
  hdr_cnt_t             hcnt;
  logic                 too_long;
  logic [SW-1:0]        need;
  logic                 over;

  assign len = in_value[LEN_WIDTH-1:0];

  // Header encoding
  always_comb begin
    hdr      = '0;
    hcnt     = 4'd1;
    plen     = '0;
    too_long = 1'b0;
    unique case (in_action)
      ACT_MAP: begin
        if (len <= 32'd15) begin
          hdr[0] = HB_FIXMAP | len[7:0];
        end else begin
          hdr[0] = HB_MAP16;
          hdr[1] = len[15:8];
          hdr[2] = len[7:0];
          hcnt   = 4'd3;
        end
      end
      ACT_UINT: begin
        if (in_value < 64'd128) begin
          hdr[0] = in_value[7:0];
        end else if (in_value <= 64'hFF) begin
          hdr[0] = HB_UINT8;
          hdr[1] = in_value[7:0];
          hcnt   = 4'd2;
        end else if (in_value <= 64'hFFFF) begin
          hdr[0] = HB_UINT16;
          hdr[1] = in_value[15:8];
          hdr[2] = in_value[7:0];
          hcnt   = 4'd3;
        end else if (in_value <= 64'hFFFF_FFFF) begin
          hdr[0] = HB_UINT32;
          hdr[1] = in_value[31:24];
          hdr[2] = in_value[23:16];
          hdr[3] = in_value[15:8];
          hdr[4] = in_value[7:0];
          hcnt   = 4'd5;
        end else begin
          hdr[0] = HB_UINT64;
          for (int k = 0; k < 8; k++) begin
            hdr[k+1] = in_value[63-8*k -: 8];
          end
          hcnt = 4'd9;
        end
      end
      ACT_STR: begin
        plen = len;
        if (len < 32'd32) begin
          hdr[0] = HB_FIXSTR | len[7:0];
        end else if (len <= LEN16_MAX) begin
          hdr[0] = HB_STR16;
          hdr[1] = len[15:8];
          hdr[2] = len[7:0];
          hcnt   = 4'd3;
        end else begin
          hdr[0] = HB_STR32;
          hdr[1] = len[31:24];
          hdr[2] = len[23:16];
          hdr[3] = len[15:8];
          hdr[4] = len[7:0];
          hcnt   = 4'd5;
        end
      end
      ACT_BIN: begin
        plen = len;
        if (len <= 32'hFF) begin
          hdr[0] = HB_BIN8;
          hdr[1] = len[7:0];
          hcnt   = 4'd2;
        end else if (len <= LEN16_MAX) begin
          hdr[0] = HB_BIN16;
          hdr[1] = len[15:8];
          hdr[2] = len[7:0];
          hcnt   = 4'd3;
        end else begin
          too_long = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Room check for header and the payload it reserves
  assign need = SW'(wp_r) + SW'(plen) + SW'(hcnt);
  assign over = need > SW'(cap_r);

  always_comb begin
    job        = '0;
    job.cnt    = 4'd1;
    job.status = ST_OK;
    wp_nxt     = wp_r;
    pl_nxt     = pl_r;
    unique case (in_action)
      ACT_RESET: begin
        wp_nxt = '0;
        pl_nxt = '0;
      end
      ACT_PAYLOAD: begin
        if (pl_r == '0) begin
          job.status = ST_UNEXP;
        end else begin
          job.bytes[0] = in_data_byte;
          job.bvalid   = 1'b1;
          pl_nxt       = pl_r - 1'b1;
          wp_nxt       = wp_r + 1'b1;
        end
      end
      ACT_MAP, ACT_UINT, ACT_STR, ACT_BIN: begin
        pl_nxt = '0;
        if (too_long) begin
          job.status = ST_TOO_LONG;
        end else if (over) begin
          job.status = ST_NO_SPACE;
        end else begin
          job.bytes  = hdr;
          job.cnt    = hcnt;
          job.bvalid = 1'b1;
          wp_nxt     = wp_r + POS_WIDTH'(hcnt);
          pl_nxt     = plen;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      wp_r  <= '0;
      pl_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (push) begin
        wp_r <= wp_nxt;
        pl_r <= pl_nxt;
      end
    end
  end

endmodule : msgser_front

`default_nettype wire

[hdl/msgser_queue.sv]
// ----------------------------------------------------------------------------
// msgser_queue: job queue between front end and emit stage
// Small register FIFO; the head entry is presented without a read delay.
// ----------------------------------------------------------------------------
`default_nettype none

module msgser_queue
  import msgser_pkg::*;
#(
  parameter int Q_DEPTH = Q_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_t            mem_r [Q_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     cnt_r;

  assign full  = cnt_r == (AW+1)'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule : msgser_queue

`default_nettype wire

[hdl/msgser_back.sv]
// ----------------------------------------------------------------------------
// msgser_back: emit stage
// Walks the head job one byte per cycle, while out_ready allows, into the
// output register and pops the job with its final word.
// ----------------------------------------------------------------------------
`default_nettype none

module msgser_back
  import msgser_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t head,
  input  wire logic empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_byte,
  output logic      out_byte_valid,
  output logic [1:0] out_status,
  output logic      out_last
);

  hdr_cnt_t   idx_r;
  logic       vld_r;
  logic [7:0] byte_r;
  logic       bval_r;
  logic [1:0] stat_r;
  logic       last_r;

  logic       load;
  logic       at_end;

  assign load   = !empty && (!vld_r || out_ready);
  assign at_end = idx_r == (head.cnt - 4'd1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= at_end ? '0 : idx_r + 4'd1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      bval_r <= head.bvalid;
      stat_r <= head.status;
      last_r <= at_end;
    end
  end

  assign out_valid      = vld_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bval_r;
  assign out_status     = stat_r;
  assign out_last       = last_r;

endmodule : msgser_back

`default_nettype wire

[hdl/msgser_top.sv]
// ----------------------------------------------------------------------------
// msgpack_subset_serializer_top: MessagePack subset serializer
// Front end decodes and accounts space, a job queue decouples it from the
// emit stage, which streams one result word per cycle while out_ready allows.
// ----------------------------------------------------------------------------
// Path: an accepted item goes into a queue entry, then the output register.
// Throughput: one item per cycle into the queue while it is not full; the
//   emit stage puts out one word per cycle when out_ready allows, one word
//   per header byte (1 to 9) and one per payload byte or single-word item.
// Reset: synchronous, active low; clears position, pending payload count,
//   queue pointers and output valid flag, and loads capacity with 4096.
`default_nettype none

module msgpack_subset_serializer_top
  import msgser_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int Q_DEPTH   = Q_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_action,
  input  wire logic [63:0]          in_value,
  input  wire logic [7:0]           in_data_byte,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_byte_valid,
  output logic [1:0]                out_status,
  output logic                      out_last,
  // capacity register
  input  wire logic                 cfg_wr_en,
  input  wire logic [CAP_WIDTH-1:0] cfg_wr_data
);

  job_t job;
  job_t head;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;

  // Take a word whenever the queue has a free slot; the emit side never
  // back-pressures the decode side directly.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  msgser_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_action    (in_action),
    .in_value     (in_value),
    .in_data_byte (in_data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .job          (job)
  );

  // Hold decoded jobs until the emit stage drains them
  msgser_queue #(
    .Q_DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Advance through the head job one byte per accepted output word
  msgser_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  // A word without a byte is always the sole, zeroed word of its item
  a_empty_word_alone : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && (out_byte == 8'd0))
    else $error("empty word not final or not zero");

  // An error status never comes with an emitted byte
  a_err_no_byte : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_byte_valid)
    else $error("error status carries a byte");

  // Reset drops the output register
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule : msgpack_subset_serializer_top

`default_nettype wire
